>>> src/usc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_pkg
// Constants, field types and the March-based month offset table for the
// seconds counter to calendar converter.
// ----------------------------------------------------------------------------
package usc_pkg;

	typedef logic [31:0] secs_t;
	typedef logic [11:0] year_t;
	typedef logic [3:0]  month_t;
	typedef logic [4:0]  mday_t;
	typedef logic [4:0]  hour_t;
	typedef logic [5:0]  minsec_t;
	typedef logic [2:0]  wday_t;

	// conversion direction on func
	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	localparam int SECS_PER_DAY = 86400;
	localparam int EPOCH_JDN    = 2440588;
	localparam int GREG_OFFSET  = 32045;
	localparam int INV_OFFSET   = 32044;
	localparam int DAYS_400Y    = 146097;
	localparam int DAYS_4Y      = 1461;
	localparam int YEAR_SHIFT   = 4800;

	localparam int PIPE_DEPTH   = 8;

	// encode: day count of the epoch on the shifted scale
	localparam int JDN_BIAS     = GREG_OFFSET + EPOCH_JDN;

	// decode: a = day + A_OFF, century index b is one of three values
	localparam int A_OFF        = EPOCH_JDN + INV_OFFSET;
	localparam int B_MIN        = 67;
	localparam int DAY_B68      = ((B_MIN + 1) * DAYS_400Y) / 4 - A_OFF;
	localparam int DAY_B69      = ((B_MIN + 2) * DAYS_400Y) / 4 - A_OFF;
	localparam int C_B67        = A_OFF - (B_MIN * DAYS_400Y) / 4;

	// weekday of the epoch, Monday is zero
	localparam int EPOCH_WDAY   = (EPOCH_JDN % 7);

	// reciprocal multipliers for division by constants
	localparam int DAY_SHIFT    = 25;
	localparam int DAY_RECIP    = (1 << DAY_SHIFT) / (SECS_PER_DAY / 128);
	localparam int Y100_SHIFT   = 19;
	localparam int Y100_RECIP   = ((1 << Y100_SHIFT) + 99) / 100;
	localparam int HOUR_SHIFT   = 29;
	localparam int HOUR_RECIP   = ((1 << HOUR_SHIFT) + 3599) / 3600;
	localparam int MIN_SHIFT    = 18;
	localparam int MIN_RECIP    = ((1 << MIN_SHIFT) + 59) / 60;
	localparam int WD_SHIFT     = 19;
	localparam int WD_RECIP     = ((1 << WD_SHIFT) + 6) / 7;
	localparam int D4Y_SHIFT    = 29;
	localparam int D4Y_RECIP    = ((1 << D4Y_SHIFT) + DAYS_4Y - 1) / DAYS_4Y;
	localparam int MON_SHIFT    = 19;
	localparam int MON_RECIP    = ((1 << MON_SHIFT) + 152) / 153;

	// days from March 1 to the start of March-based month m: (153*m+2)/5
	function automatic logic [8:0] mar_days(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			4'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> src/unix_seconds_calendar_convert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unix_seconds_calendar_convert_core
// Seconds since 1970-01-01 to and from Gregorian date and time, by way of
// the Julian day number, in an eight stage pipeline.
// ----------------------------------------------------------------------------
// usage
//   A beat is taken at a rising edge with start high and busy low. busy is
//   tied low: the pipeline takes a beat in every cycle.
//   func = 0 encodes year/month/day/hour/minute/second into seconds_out
//   (modulo 2^32, day of month unchecked); the date, time and weekday outputs are zero.
//   func = 1 decodes seconds_in into date, time and weekday (Monday = 0);
//   seconds_out is zero.
//   Each result is shown for one cycle with done high, once its beat has
//   passed through every stage of the pipeline.
//   Throughput is one beat per cycle; latency is set by the chain of
//   reciprocal multiplies (day split, century/year split, month split).
//   The receiver cannot stall, so there is no back pressure path.
//   Reset clears the stage valid bits; no result is shown until the
//   pipeline has been refilled.
// ----------------------------------------------------------------------------
module unix_seconds_calendar_convert_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output logic                 done,
	input  logic                 func,
	input  usc_pkg::secs_t       seconds_in,
	input  usc_pkg::year_t       year_in,
	input  usc_pkg::month_t      month_in,
	input  usc_pkg::mday_t       day_in,
	input  usc_pkg::hour_t       hour_in,
	input  usc_pkg::minsec_t     minute_in,
	input  usc_pkg::minsec_t     second_in,
	output usc_pkg::secs_t       seconds_out,
	output usc_pkg::year_t       year_out,
	output usc_pkg::month_t      month_out,
	output usc_pkg::mday_t       day_out,
	output usc_pkg::hour_t       hour_out,
	output usc_pkg::minsec_t     minute_out,
	output usc_pkg::minsec_t     second_out,
	output usc_pkg::wday_t       weekday_out
);

	logic [usc_pkg::PIPE_DEPTH-1:0] vld_s;
	logic [usc_pkg::PIPE_DEPTH-1:0] func_s;
	logic accept;

	// encode path
	logic        early;
	logic [3:0]  m_enc;
	logic [13:0] y_s1;
	logic [8:0]  moff_s1;
	logic [4:0]  dayE_s1;
	logic [4:0]  hourE_s1;
	logic [5:0]  minE_s1;
	logic [5:0]  secE_s1;
	logic [26:0] y100_prod;
	logic [21:0] y365_s2;
	logic [11:0] y4_s2;
	logic [7:0]  y100_s2;
	logic [8:0]  moff_s2;
	logic [4:0]  dayE_s2;
	logic [16:0] tode_s2;
	logic [21:0] jdn_enc;
	logic [31:0] days_s3;
	logic [16:0] tode_s3;
	logic [31:0] eprod_s4;
	logic [16:0] tode_s4;
	logic [31:0] enc_s5;
	logic [31:0] enc_s6;
	logic [31:0] enc_s7;

	// decode path
	logic [40:0] q0_prod;
	logic [31:0] cnt_s1;
	logic [15:0] q0_s1;
	logic [32:0] r0_full;
	logic [17:0] r0_s2;
	logic [15:0] q0_s2;
	logic        r0_ovf;
	logic [15:0] day_s3;
	logic [16:0] tod_s3;
	logic        b68;
	logic        b69;
	logic [15:0] c_next;
	logic [34:0] hour_prod;
	logic [15:0] w_next;
	logic [32:0] wd_prod;
	logic [6:0]  b_s4;
	logic [15:0] c_s4;
	logic [4:0]  hour_s4;
	logic [16:0] tod_s4;
	logic [15:0] w_s4;
	logic [13:0] q7_s4;
	logic [36:0] d_prod;
	logic [6:0]  b_s5;
	logic [15:0] c_s5;
	logic [6:0]  d_s5;
	logic [4:0]  hour_s5;
	logic [11:0] hrem_s5;
	logic [2:0]  wd_s5;
	logic [24:0] min_prod;
	logic [6:0]  b_s6;
	logic [8:0]  e_s6;
	logic [6:0]  d_s6;
	logic [4:0]  hour_s6;
	logic [5:0]  minute_s6;
	logic [11:0] hrem_s6;
	logic [2:0]  wd_s6;
	logic [22:0] mon_prod;
	logic [6:0]  b_s7;
	logic [8:0]  e_s7;
	logic [6:0]  d_s7;
	logic [3:0]  m_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  minute_s7;
	logic [5:0]  sec_s7;
	logic [2:0]  wd_s7;
	logic        wrap;
	logic [12:0] year_full;

	// output stage
	logic [31:0] seconds_s8;
	logic [11:0] year_s8;
	logic [3:0]  month_s8;
	logic [4:0]  mday_s8;
	logic [4:0]  hour_s8;
	logic [5:0]  minute_s8;
	logic [5:0]  second_s8;
	logic [2:0]  wday_s8;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign done   = vld_s[usc_pkg::PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[usc_pkg::PIPE_DEPTH-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		func_s <= {func_s[usc_pkg::PIPE_DEPTH-2:0], func};
	end

	// ---------------- encode ----------------
	always_comb begin
		early     = (month_in <= 4'd2);
		m_enc     = early ? (month_in + 4'd9) : (month_in - 4'd3);
		y100_prod = 27'(y_s1) * 27'(usc_pkg::Y100_RECIP);
		jdn_enc   = 22'(dayE_s2) + 22'(moff_s2) + y365_s2 + 22'(y4_s2)
		          - 22'(y100_s2) + 22'(y100_s2 >> 2);
	end

	always_ff @(posedge clk) begin
		y_s1     <= 14'(year_in) + 14'(usc_pkg::YEAR_SHIFT) - 14'(early);
		moff_s1  <= usc_pkg::mar_days(m_enc);
		dayE_s1  <= day_in;
		hourE_s1 <= hour_in;
		minE_s1  <= minute_in;
		secE_s1  <= second_in;

		y365_s2  <= 22'(y_s1) * 22'd365;
		y4_s2    <= 12'(y_s1 >> 2);
		y100_s2  <= 8'(y100_prod >> usc_pkg::Y100_SHIFT);
		moff_s2  <= moff_s1;
		dayE_s2  <= dayE_s1;
		tode_s2  <= 17'(hourE_s1) * 17'd3600 + 17'(minE_s1) * 17'd60 + 17'(secE_s1);

		days_s3  <= 32'(jdn_enc) - 32'(usc_pkg::JDN_BIAS);
		tode_s3  <= tode_s2;

		eprod_s4 <= days_s3 * 32'(usc_pkg::SECS_PER_DAY);
		tode_s4  <= tode_s3;

		enc_s5   <= eprod_s4 + 32'(tode_s4);
		enc_s6   <= enc_s5;
		enc_s7   <= enc_s6;
	end

	// ---------------- decode ----------------
	always_comb begin
		// day estimate from count / 128 / 675, low by at most one
		q0_prod   = 41'(seconds_in[31:7]) * 41'(usc_pkg::DAY_RECIP);
		r0_full   = 33'(cnt_s1) - 33'(q0_s1) * 33'(usc_pkg::SECS_PER_DAY);
		r0_ovf    = (r0_s2 >= 18'(usc_pkg::SECS_PER_DAY));
		b68       = (day_s3 >= 16'(usc_pkg::DAY_B68));
		b69       = (day_s3 >= 16'(usc_pkg::DAY_B69));
		if (b69) begin
			c_next = day_s3 - 16'(usc_pkg::DAY_B69);
		end else if (b68) begin
			c_next = day_s3 - 16'(usc_pkg::DAY_B68);
		end else begin
			c_next = day_s3 + 16'(usc_pkg::C_B67);
		end
		hour_prod = 35'(tod_s3) * 35'(usc_pkg::HOUR_RECIP);
		w_next    = day_s3 + 16'(usc_pkg::EPOCH_WDAY);
		wd_prod   = 33'(w_next) * 33'(usc_pkg::WD_RECIP);
		d_prod    = 37'({c_s4, 2'b11}) * 37'(usc_pkg::D4Y_RECIP);
		min_prod  = 25'(hrem_s5) * 25'(usc_pkg::MIN_RECIP);
		mon_prod  = 23'(11'(e_s6) * 11'd5 + 11'd2) * 23'(usc_pkg::MON_RECIP);
		wrap      = (m_s7 >= 4'd10);
		year_full = 13'(b_s7) * 13'd100 + 13'(d_s7) + 13'(wrap)
		          - 13'(usc_pkg::YEAR_SHIFT);
	end

	always_ff @(posedge clk) begin
		cnt_s1    <= seconds_in;
		q0_s1     <= 16'(q0_prod >> usc_pkg::DAY_SHIFT);

		r0_s2     <= 18'(r0_full);
		q0_s2     <= q0_s1;

		day_s3    <= q0_s2 + 16'(r0_ovf);
		tod_s3    <= r0_ovf ? 17'(r0_s2 - 18'(usc_pkg::SECS_PER_DAY)) : 17'(r0_s2);

		b_s4      <= 7'(usc_pkg::B_MIN) + 7'(b68) + 7'(b69);
		c_s4      <= c_next;
		hour_s4   <= 5'(hour_prod >> usc_pkg::HOUR_SHIFT);
		tod_s4    <= tod_s3;
		w_s4      <= w_next;
		q7_s4     <= 14'(wd_prod >> usc_pkg::WD_SHIFT);

		b_s5      <= b_s4;
		c_s5      <= c_s4;
		d_s5      <= 7'(d_prod >> usc_pkg::D4Y_SHIFT);
		hour_s5   <= hour_s4;
		hrem_s5   <= 12'(tod_s4 - 17'(hour_s4) * 17'd3600);
		wd_s5     <= 3'(w_s4 - 16'(q7_s4) * 16'd7);

		b_s6      <= b_s5;
		e_s6      <= 9'(c_s5 - 16'((18'(d_s5) * 18'(usc_pkg::DAYS_4Y)) >> 2));
		d_s6      <= d_s5;
		hour_s6   <= hour_s5;
		minute_s6 <= 6'(min_prod >> usc_pkg::MIN_SHIFT);
		hrem_s6   <= hrem_s5;
		wd_s6     <= wd_s5;

		b_s7      <= b_s6;
		e_s7      <= e_s6;
		d_s7      <= d_s6;
		m_s7      <= 4'(mon_prod >> usc_pkg::MON_SHIFT);
		hour_s7   <= hour_s6;
		minute_s7 <= minute_s6;
		sec_s7    <= 6'(hrem_s6 - 12'(minute_s6) * 12'd60);
		wd_s7     <= wd_s6;

		// output stage: one direction's fields, the other side zero
		if (func_s[usc_pkg::PIPE_DEPTH-2] == usc_pkg::FUNC_DECODE) begin
			seconds_s8 <= '0;
			year_s8    <= 12'(year_full);
			month_s8   <= wrap ? (m_s7 - 4'd9) : (m_s7 + 4'd3);
			mday_s8    <= 5'(e_s7 - usc_pkg::mar_days(m_s7) + 9'd1);
			hour_s8    <= hour_s7;
			minute_s8  <= minute_s7;
			second_s8  <= sec_s7;
			wday_s8    <= wd_s7;
		end else begin
			seconds_s8 <= enc_s7;
			year_s8    <= '0;
			month_s8   <= '0;
			mday_s8    <= '0;
			hour_s8    <= '0;
			minute_s8  <= '0;
			second_s8  <= '0;
			wday_s8    <= '0;
		end
	end

	assign seconds_out = seconds_s8;
	assign year_out    = year_s8;
	assign month_out   = month_s8;
	assign day_out     = mday_s8;
	assign hour_out    = hour_s8;
	assign minute_out  = minute_s8;
	assign second_out  = second_s8;
	assign weekday_out = wday_s8;

	// ---------------- assertions ----------------
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, usc_pkg::PIPE_DEPTH))
		else $error("result beat without a matching start beat");

	a_day_correction: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[1] |-> (r0_s2 < 18'(2 * usc_pkg::SECS_PER_DAY)))
		else $error("day estimate off by more than one");

	a_century_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[4] |-> (c_s5 <= 16'd36524))
		else $error("century remainder out of range");

	a_year_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5] |-> (e_s6 <= 9'd365))
		else $error("day of year out of range");

	a_decode_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && func_s[usc_pkg::PIPE_DEPTH-1] == usc_pkg::FUNC_DECODE) |->
		(month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1
		 && hour_out <= 5'd23 && minute_out <= 6'd59 && second_out <= 6'd59
		 && weekday_out <= 3'd6))
		else $error("decoded field out of range");

endmodule
